@@ hw/rtl/ialf_pkg.sv @@
`timescale 1ns / 1ps

package ialf_pkg;

  // Operation codes
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_ALLOC  = 2'd0;
  localparam opcode_t OP_FREE   = 2'd1;
  localparam opcode_t OP_ATTACH = 2'd2;

  // Status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK           = 3'd0;
  localparam status_t ST_EXHAUSTED    = 3'd1;
  localparam status_t ST_NOT_ATTACHED = 3'd2;
  localparam status_t ST_ATTACHED     = 3'd3;
  localparam status_t ST_FULL         = 3'd4;

  localparam int FIELD_BITS = 32;

  // Request item
  typedef struct packed {
    opcode_t                 opcode;
    logic [1:0]              volume;
    logic [FIELD_BITS-1:0]   freed_index;
  } req_t;

  // Response item
  typedef struct packed {
    logic [FIELD_BITS-1:0]   alloc_index;
    status_t                 status;
  } rsp_t;

  // Flags from the shared interval comparator
  typedef struct packed {
    logic lo_hit;   // interval starts just above the index
    logic hi_hit;   // interval ends just below the index
    logic below;    // index lies below the interval start
    logic drained;  // interval holds a single index
  } cmp_flags_t;

endpackage

@@ hw/rtl/ialf_cmp.sv @@
`timescale 1ns / 1ps

module ialf_cmp #(
  parameter int INDEX_BITS = 32
) (
  input  logic [INDEX_BITS-1:0] first,
  input  logic [INDEX_BITS-1:0] last,
  input  logic [INDEX_BITS-1:0] idx,
  output ialf_pkg::cmp_flags_t  flags
);
  import ialf_pkg::*;

  logic [INDEX_BITS:0] idx_inc;
  logic [INDEX_BITS:0] last_inc;

  // No wrap: one extra bit on both increments
  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign last_inc = {1'b0, last} + 1'b1;

  assign flags.lo_hit  = ({1'b0, first} == idx_inc);
  assign flags.hi_hit  = (last_inc == {1'b0, idx});
  assign flags.below   = (idx < first);
  assign flags.drained = (first >= last);

endmodule

@@ hw/rtl/ialf_ctrl.sv @@
`timescale 1ns / 1ps

module ialf_ctrl #(
  parameter int INDEX_BITS    = 32,
  parameter int MAX_INTERVALS = 16,
  parameter int VOLUMES       = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ialf_pkg::req_t req,
  output logic           idle,
  output logic           res_valid,
  input  logic           res_take,
  output ialf_pkg::rsp_t res
);
  import ialf_pkg::*;

  localparam int VB    = (VOLUMES > 1) ? $clog2(VOLUMES) : 1;
  localparam int KB    = $clog2(MAX_INTERVALS);
  localparam int CB    = $clog2(MAX_INTERVALS + 1);
  localparam int EB    = 2 * INDEX_BITS;
  localparam int DEPTH = VOLUMES << KB;
  localparam int AB    = VB + KB;
  localparam logic [CB-1:0] CNT_MAX = CB'(MAX_INTERVALS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_A_FETCH, S_A_EVAL, S_F_FETCH, S_F_EVAL, S_P_CHK,
    S_N_FETCH, S_N_EVAL, S_D_FETCH, S_D_WRITE, S_U_FETCH, S_U_WRITE,
    S_INS_W, S_END, S_DONE
  } state_t;

  state_t                state;
  opcode_t               op;
  logic [1:0]            vol;
  logic [INDEX_BITS-1:0] idx;
  logic [CB-1:0]         ptr;
  logic [CB-1:0]         ins;
  logic [CB-1:0]         cnt_w;
  logic [EB-1:0]         cur;
  logic [EB-1:0]         prev;
  logic [EB-1:0]         rdata;
  status_t               st;
  logic [INDEX_BITS-1:0] result;

  // Per-volume state
  logic                  active [VOLUMES];
  logic [INDEX_BITS:0]   nu     [VOLUMES];
  logic [CB-1:0]         cnt    [VOLUMES];

  // Interval table, one row of 2**KB entries per volume
  logic [EB-1:0]         mem    [DEPTH];

  logic [VB-1:0]         vix;
  logic                  vol_ok;
  logic [INDEX_BITS:0]   nu_v;
  logic [CB-1:0]         cnt_v;
  logic [INDEX_BITS:0]   idx_inc;
  logic [CB-1:0]         ptr_inc;
  logic [CB-1:0]         ptr_dec;
  logic [AB-1:0]         raddr;
  logic                  we;
  logic [AB-1:0]         waddr;
  logic [EB-1:0]         wdata;
  logic [EB-1:0]         cmp_ent;
  cmp_flags_t            flags;

  logic [INDEX_BITS-1:0] r_first, r_last, c_first, c_last, p_first;

  assign vix     = VB'(vol);
  assign vol_ok  = 32'(vol) < VOLUMES;
  assign nu_v    = nu[vix];
  assign cnt_v   = cnt[vix];
  assign idx_inc = {1'b0, idx} + 1'b1;
  assign ptr_inc = ptr + 1'b1;
  assign ptr_dec = ptr - 1'b1;
  assign raddr   = {vix, ptr[KB-1:0]};

  assign r_first = rdata[EB-1:INDEX_BITS];
  assign r_last  = rdata[INDEX_BITS-1:0];
  assign c_first = cur[EB-1:INDEX_BITS];
  assign c_last  = cur[INDEX_BITS-1:0];
  assign p_first = prev[EB-1:INDEX_BITS];

  // Shared comparator: previous entry during the merge check, else read data
  assign cmp_ent = (state == S_P_CHK) ? prev : rdata;

  ialf_cmp #(.INDEX_BITS(INDEX_BITS)) u_cmp (
    .first (cmp_ent[EB-1:INDEX_BITS]),
    .last  (cmp_ent[INDEX_BITS-1:0]),
    .idx   (idx),
    .flags (flags)
  );

  // Table write port
  always_comb begin
    we    = 1'b0;
    waddr = {vix, ptr[KB-1:0]};
    wdata = rdata;
    unique case (state)
      S_A_EVAL: begin
        if (!flags.drained) begin
          we    = 1'b1;
          wdata = {r_first + 1'b1, r_last};
        end
      end
      S_F_EVAL: begin
        if (flags.lo_hit) begin
          we    = (ptr == '0);
          wdata = {idx, r_last};
        end else if (flags.hi_hit) begin
          we    = !(ptr_inc < cnt_w);
          wdata = {r_first, idx};
        end
      end
      S_P_CHK: begin
        we = 1'b1;
        if (flags.hi_hit) begin
          waddr = {vix, ptr_dec[KB-1:0]};
          wdata = {p_first, c_last};
        end else begin
          wdata = {idx, c_last};
        end
      end
      S_N_EVAL: begin
        we    = 1'b1;
        waddr = {vix, ptr_dec[KB-1:0]};
        wdata = flags.lo_hit ? {c_first, r_last} : {c_first, idx};
      end
      S_D_WRITE: begin
        we    = 1'b1;
        waddr = {vix, ptr_dec[KB-1:0]};
      end
      S_U_WRITE: begin
        we    = 1'b1;
        waddr = {vix, ptr_inc[KB-1:0]};
      end
      S_INS_W: begin
        we    = 1'b1;
        waddr = {vix, ins[KB-1:0]};
        wdata = {idx, idx};
      end
      S_END: begin
        we    = (cnt_w != CNT_MAX);
        waddr = {vix, cnt_w[KB-1:0]};
        wdata = {idx, idx};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Table memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int v = 0; v < VOLUMES; v++) begin
        active[v] <= 1'b0;
        nu[v]     <= '0;
        cnt[v]    <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op    <= req.opcode;
            vol   <= req.volume;
            idx   <= req.freed_index[INDEX_BITS-1:0];
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          st     <= ST_OK;
          result <= '0;
          cnt_w  <= cnt_v;
          ptr    <= '0;
          state  <= S_DONE;
          priority if (op == OP_ATTACH) begin
            priority if (!vol_ok) begin
              st <= ST_NOT_ATTACHED;
            end else if (active[vix]) begin
              st <= ST_ATTACHED;
            end else begin
              active[vix] <= 1'b1;
              nu[vix]     <= '0;
              cnt[vix]    <= '0;
            end
          end else if (op == OP_ALLOC || op == OP_FREE) begin
            priority if (!vol_ok || !active[vix]) begin
              st <= ST_NOT_ATTACHED;
            end else if (op == OP_ALLOC) begin
              priority if (cnt_v != '0) begin
                state <= S_A_FETCH;
              end else if (!nu_v[INDEX_BITS]) begin
                result  <= nu_v[INDEX_BITS-1:0];
                nu[vix] <= nu_v + 1'b1;
              end else begin
                st <= ST_EXHAUSTED;
              end
            end else begin
              priority if (idx_inc == nu_v) begin
                nu[vix] <= {1'b0, idx};
              end else if (cnt_v == '0) begin
                state <= S_END;
              end else begin
                state <= S_F_FETCH;
              end
            end
          end
        end
        S_A_FETCH: state <= S_A_EVAL;
        S_A_EVAL: begin
          result <= r_first;
          state  <= S_DONE;
          if (flags.drained) begin
            cnt[vix] <= cnt_w - 1'b1;
            ptr      <= ptr_inc;
            state    <= (ptr_inc < cnt_w) ? S_D_FETCH : S_DONE;
          end
        end
        S_F_FETCH: state <= S_F_EVAL;
        S_F_EVAL: begin
          cur <= rdata;
          priority if (flags.lo_hit) begin
            state <= (ptr != '0) ? S_P_CHK : S_DONE;
          end else if (flags.hi_hit) begin
            if (ptr_inc < cnt_w) begin
              ptr   <= ptr_inc;
              state <= S_N_FETCH;
            end else begin
              state <= S_DONE;
            end
          end else if (flags.below) begin
            if (cnt_w == CNT_MAX) begin
              st    <= ST_FULL;
              state <= S_DONE;
            end else begin
              cnt[vix] <= cnt_w + 1'b1;
              ins      <= ptr;
              ptr      <= cnt_w - 1'b1;
              state    <= S_U_FETCH;
            end
          end else begin
            prev  <= rdata;
            ptr   <= ptr_inc;
            state <= (ptr_inc < cnt_w) ? S_F_FETCH : S_END;
          end
        end
        // Merge with the interval below, then drop this entry; else extend it down
        S_P_CHK: begin
          state <= S_DONE;
          if (flags.hi_hit) begin
            cnt[vix] <= cnt_w - 1'b1;
            ptr      <= ptr_inc;
            state    <= (ptr_inc < cnt_w) ? S_D_FETCH : S_DONE;
          end
        end
        S_N_FETCH: state <= S_N_EVAL;
        // Merge with the interval above, then drop it; else extend this entry up
        S_N_EVAL: begin
          state <= S_DONE;
          if (flags.lo_hit) begin
            cnt[vix] <= cnt_w - 1'b1;
            ptr      <= ptr_inc;
            state    <= (ptr_inc < cnt_w) ? S_D_FETCH : S_DONE;
          end
        end
        S_D_FETCH: state <= S_D_WRITE;
        S_D_WRITE: begin
          ptr   <= ptr_inc;
          state <= (ptr_inc < cnt_w) ? S_D_FETCH : S_DONE;
        end
        S_U_FETCH: state <= S_U_WRITE;
        S_U_WRITE: begin
          if (ptr == ins) begin
            state <= S_INS_W;
          end else begin
            ptr   <= ptr_dec;
            state <= S_U_FETCH;
          end
        end
        S_INS_W: state <= S_DONE;
        // Append at the tail, or report full
        S_END: begin
          if (cnt_w == CNT_MAX) begin
            st <= ST_FULL;
          end else begin
            cnt[vix] <= cnt_w + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle            = (state == S_IDLE);
  assign res_valid       = (state == S_DONE);
  assign res.alloc_index = FIELD_BITS'(result);
  assign res.status      = st;

  // Checks
  a_shift_up_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_U_WRITE) |-> (ptr >= ins))
    else $error("shift-up pointer passed insertion point");

  a_write_in_row: assert property (@(posedge clk) disable iff (rst)
    we |-> (32'(waddr[KB-1:0]) < MAX_INTERVALS))
    else $error("table write beyond volume row");

  a_full_only_free: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (st != ST_FULL || op == OP_FREE))
    else $error("table full reported for non-free");

  a_shift_down_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_D_WRITE) |-> (ptr < cnt_w && ptr != '0))
    else $error("shift-down pointer out of range");

endmodule

@@ hw/rtl/index_allocator_interval_freelist_top.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Item
// req      in         req_valid/req_stall   ialf_pkg::req_t
// rsp      out        rsp_valid/rsp_stall   ialf_pkg::rsp_t
//
// One item at a time; req_stall is high from acceptance until the result is
// handed to the response register. Attach, counter allocate and counter free
// finish in the decode state; table work fetches each entry visited or moved
// from the interval table, which has a registered read, before it evaluates
// or writes it, and a free may walk or shift the whole table.
// Reset is synchronous; the table itself needs no clearing pass.
// The response register lets the next item be accepted while a result waits.

module index_allocator_interval_freelist_top #(
  parameter int INDEX_BITS    = 32,
  parameter int MAX_INTERVALS = 16,
  parameter int VOLUMES       = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ialf_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ialf_pkg::rsp_t rsp
);
  import ialf_pkg::*;

  logic idle;
  logic res_valid;
  logic res_take;
  rsp_t res;

  assign req_stall = !idle;
  assign res_take  = !rsp_valid || !rsp_stall;

  ialf_ctrl #(
    .INDEX_BITS    (INDEX_BITS),
    .MAX_INTERVALS (MAX_INTERVALS),
    .VOLUMES       (VOLUMES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (req_valid && idle),
    .req       (req),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp <= res;
    end
  end

endmodule
